// File: design/mfsgd_pkg.sv
// ----------------------------------------------------------------------------
// mfsgd_pkg: shared types and constants of the matrix factorization SGD engine
// Table sizes, field widths, command and state codes, and Q16.32 helpers.
// ----------------------------------------------------------------------------
package mfsgd_pkg;

	localparam int USERS             = 256;
	localparam int ITEMS             = 4096;
	localparam int FEATURES          = 16;
	localparam int CONTEXT_VARIABLES = 12;
	localparam int CONTEXT_CLASSES   = 8;

	// Field widths fixed by the stream format.
	localparam int VAL_W   = 48;
	localparam int GB_W    = 35;
	localparam int RATE_W  = 32;
	localparam int FIU_W   = 5;
	localparam int MASK_W  = 12;
	localparam int USER_W  = 8;
	localparam int ITEM_W  = 12;
	localparam int FEAT_W  = 4;
	localparam int CVAR_W  = 4;
	localparam int CLS_W   = 3;
	localparam int CLSS_W  = 36;
	localparam int SCORE_W = 8;
	localparam int CFG_IW  = 3;

	// Multiplier operands are signed Q16.32 with one guard bit.
	localparam int MOP_W  = VAL_W + 1;
	localparam int HALF_W = VAL_W / 2;
	localparam int PROD_W = 2 * VAL_W;
	localparam int ACC_W  = 56;

	localparam int UF_DEPTH  = USERS * FEATURES;
	localparam int IF_DEPTH  = ITEMS * FEATURES;
	localparam int CTX_DEPTH = CONTEXT_VARIABLES * USERS * CONTEXT_CLASSES;
	localparam int UF_AW     = $clog2(UF_DEPTH);
	localparam int IF_AW     = $clog2(IF_DEPTH);
	localparam int UB_AW     = $clog2(USERS);
	localparam int IB_AW     = $clog2(ITEMS);
	localparam int CTX_AW    = $clog2(CTX_DEPTH);
	localparam int FC_W      = $clog2(FEATURES + 1);
	localparam int FI_W      = $clog2(FEATURES);
	localparam int VC_W      = $clog2(CONTEXT_VARIABLES + 1);

	localparam logic [GB_W-1:0] PRED_MIN = GB_W'(64'h1_0000_0000);
	localparam logic [GB_W-1:0] PRED_MAX = GB_W'(64'h5_0000_0000);

	localparam logic [CFG_IW-1:0] CFG_GLOBAL_BIAS   = 3'd0;
	localparam logic [CFG_IW-1:0] CFG_LEARNING_RATE = 3'd1;
	localparam logic [CFG_IW-1:0] CFG_REGULARIZE    = 3'd2;
	localparam logic [CFG_IW-1:0] CFG_FEATURES      = 3'd3;
	localparam logic [CFG_IW-1:0] CFG_CONTEXT_MASK  = 3'd4;

	typedef enum logic [2:0] {
		CMD_WR_UFEAT = 3'd0,
		CMD_WR_IFEAT = 3'd1,
		CMD_WR_UBIAS = 3'd2,
		CMD_WR_IBIAS = 3'd3,
		CMD_WR_CBIAS = 3'd4,
		CMD_TRAIN    = 3'd5,
		CMD_PREDICT  = 3'd6
	} cmd_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_BIAS,
		S_BIAS_ADD,
		S_CTX,
		S_CTX_ADD,
		S_FEAT,
		S_FEAT_LD,
		S_FEAT_WAIT,
		S_CLAMP,
		S_UPD_GO,
		S_UPD_WAIT,
		S_WB,
		S_FIN
	} state_t;

	// Saturate a 49-bit sum of two 48-bit values back to 48 bits.
	function automatic logic signed [VAL_W-1:0] sat48(input logic signed [MOP_W-1:0] x);
		if (x[MOP_W-1] != x[MOP_W-2]) begin
			return x[MOP_W-1] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
		end
		return x[VAL_W-1:0];
	endfunction

endpackage

// File: design/mfsgd_ram.sv
// ----------------------------------------------------------------------------
// mfsgd_ram: single-port table memory
// One access per cycle, write or read, with registered read data.
// ----------------------------------------------------------------------------
module mfsgd_ram #(
	parameter int DEPTH = 256,
	parameter int WIDTH = 48
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

// File: design/mfsgd_mul.sv
// ----------------------------------------------------------------------------
// mfsgd_mul: shared Q16.32 multiplier
// Multiplies magnitudes as four 24x24 partial products, one per cycle, then
// rounds half away from zero at bit 32 and saturates to 48 bits signed.
// ----------------------------------------------------------------------------
module mfsgd_mul (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	input  logic signed [mfsgd_pkg::MOP_W-1:0]    a,
	input  logic signed [mfsgd_pkg::MOP_W-1:0]    b,
	output logic                                  done,
	output logic signed [mfsgd_pkg::VAL_W-1:0]    res
);
	import mfsgd_pkg::*;

	logic [VAL_W-1:0]  ma_q, mb_q;
	logic              neg_q;
	logic [PROD_W-1:0] prod_q;
	logic [1:0]        step_q;
	logic              run_q, fin_q, done_q;
	logic signed [VAL_W-1:0] res_q;

	logic [MOP_W-1:0]  a_abs, b_abs;
	logic [HALF_W-1:0] a_half, b_half;
	logic [VAL_W-1:0]  pp_raw;
	logic [PROD_W-1:0] pp;
	logic [PROD_W-1:0] rsum;
	logic [63:0]       r;
	logic signed [VAL_W-1:0] r_sat;

	assign a_abs  = a[MOP_W-1] ? MOP_W'(-a) : MOP_W'(a);
	assign b_abs  = b[MOP_W-1] ? MOP_W'(-b) : MOP_W'(b);
	assign a_half = step_q[1] ? ma_q[VAL_W-1:HALF_W] : ma_q[HALF_W-1:0];
	assign b_half = step_q[0] ? mb_q[VAL_W-1:HALF_W] : mb_q[HALF_W-1:0];
	assign pp_raw = a_half * b_half;

	always_comb begin
		pp = PROD_W'(pp_raw);
		case (step_q)
			2'd0:    pp = pp;
			2'd3:    pp = pp << (2 * HALF_W);
			default: pp = pp << HALF_W;
		endcase
	end

	assign rsum = prod_q + (PROD_W'(1) << 31);
	assign r    = rsum[PROD_W-1:32];

	always_comb begin
		if (neg_q) begin
			if (r > 64'h8000_0000_0000) begin
				r_sat = {1'b1, {(VAL_W-1){1'b0}}};
			end else begin
				r_sat = VAL_W'(-r);
			end
		end else begin
			if (r > 64'h7FFF_FFFF_FFFF) begin
				r_sat = {1'b0, {(VAL_W-1){1'b1}}};
			end else begin
				r_sat = r[VAL_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			step_q <= 2'd0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q  <= 1'b1;
				step_q <= 2'd0;
			end else if (run_q) begin
				step_q <= step_q + 2'd1;
				if (step_q == 2'd3) begin
					run_q <= 1'b0;
					fin_q <= 1'b1;
				end
			end else if (fin_q) begin
				fin_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			ma_q   <= a_abs[VAL_W-1:0];
			mb_q   <= b_abs[VAL_W-1:0];
			neg_q  <= a[MOP_W-1] ^ b[MOP_W-1];
			prod_q <= '0;
		end else if (run_q) begin
			prod_q <= prod_q + pp;
		end
		if (fin_q) begin
			res_q <= r_sat;
		end
	end

	assign done = done_q;
	assign res  = res_q;

endmodule

// File: design/matrix_factorization_sgd_engine.sv
// ----------------------------------------------------------------------------
// matrix_factorization_sgd_engine: biased matrix factorization with SGD
// Table loads, prediction and single-feature training on one shared multiplier.
// ----------------------------------------------------------------------------
// The engine keeps user and item feature tables, user and item bias tables and
// a context bias table indexed by context variable, user and class, all loaded
// with write commands on the input stream (tuser carries the command). A
// predict beat returns the global bias plus the user, item and enabled context
// biases plus the dot product over the features in use, clamped to 1..5 in
// Q16.32. A train beat for feature f predicts with features 0..f, returns the
// prediction and the error, and updates feature f of the user and of the item
// by regularized SGD from their old values. Write commands complete in the
// accepting cycle. Predict and train beats run one at a time on a single
// 24x24 multiplier that builds each 48x48 product from four partial products.
// A beat steps through the bias fetch, the context walk with one more step
// for each enabled variable with a known class, a load and a product for each
// summed feature, the clamp and the hand-off to the output; a train beat adds
// the six update products and the table write-back before the hand-off.
// The input is not ready while a beat is in work; a finished result waits
// in the output register while the next beat is accepted. Tables hold no
// reset value: an entry read before it was written returns garbage.
// ----------------------------------------------------------------------------
module matrix_factorization_sgd_engine (
	input  logic                                clk,
	input  logic                                arst_n,
	// Configuration write port.
	input  logic                                cfg_we,
	input  logic [mfsgd_pkg::CFG_IW-1:0]        cfg_index,
	input  logic [mfsgd_pkg::GB_W-1:0]          cfg_data,
	// Command stream.
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// user_index[7:0], item_index[19:8], feature_index[23:20],
	// context_variable[27:24], context_class[30:28], context_classes[66:31],
	// true_score[74:67], value[122:75], zero fill to 128 bits
	input  logic [127:0]                        s_axis_tdata,
	// command[2:0]
	input  logic [2:0]                          s_axis_tuser,
	// Result stream.
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// predicted_score[34:0], error[82:35], zero fill to 88 bits
	output logic [87:0]                         m_axis_tdata
);
	import mfsgd_pkg::*;

	// Configuration registers.
	logic [GB_W-1:0]   gb_q;
	logic [RATE_W-1:0] lr_q, reg_q;
	logic [FIU_W-1:0]  fiu_q;
	logic [MASK_W-1:0] mask_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gb_q   <= '0;
			lr_q   <= RATE_W'(42950);
			reg_q  <= RATE_W'(21474836);
			fiu_q  <= FIU_W'(10);
			mask_q <= MASK_W'(1052);
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_GLOBAL_BIAS:   gb_q   <= cfg_data;
				CFG_LEARNING_RATE: lr_q   <= cfg_data[RATE_W-1:0];
				CFG_REGULARIZE:    reg_q  <= cfg_data[RATE_W-1:0];
				CFG_FEATURES:      fiu_q  <= cfg_data[FIU_W-1:0];
				CFG_CONTEXT_MASK:  mask_q <= cfg_data[MASK_W-1:0];
				default:           ;
			endcase
		end
	end

	// Input beat fields.
	logic [2:0]               in_cmd;
	logic [USER_W-1:0]        in_u;
	logic [ITEM_W-1:0]        in_it;
	logic [FEAT_W-1:0]        in_f;
	logic [CVAR_W-1:0]        in_cv;
	logic [CLS_W-1:0]         in_cc;
	logic [CLSS_W-1:0]        in_classes;
	logic [SCORE_W-1:0]       in_score;
	logic signed [VAL_W-1:0]  in_value;

	assign in_cmd     = s_axis_tuser;
	assign in_u       = s_axis_tdata[7:0];
	assign in_it      = s_axis_tdata[19:8];
	assign in_f       = s_axis_tdata[23:20];
	assign in_cv      = s_axis_tdata[27:24];
	assign in_cc      = s_axis_tdata[30:28];
	assign in_classes = s_axis_tdata[66:31];
	assign in_score   = s_axis_tdata[74:67];
	assign in_value   = s_axis_tdata[122:75];

	logic accept, u_ok, i_ok, f_ok, ctx_ok;
	assign accept = s_axis_tvalid && s_axis_tready;
	assign u_ok   = int'(in_u) < USERS;
	assign i_ok   = int'(in_it) < ITEMS;
	assign f_ok   = int'(in_f) < FEATURES;
	assign ctx_ok = int'(in_cv) < CONTEXT_VARIABLES && int'(in_cc) < CONTEXT_CLASSES;

	// Sequencer state and work registers.
	state_t state_q, state_d;
	logic [USER_W-1:0]       u_q;
	logic [ITEM_W-1:0]       it_q;
	logic [FEAT_W-1:0]       f_q;
	logic                    train_q;
	logic [CLSS_W-1:0]       classes_q;
	logic [SCORE_W-1:0]      score_q;
	logic [FC_W-1:0]         n_q, fcnt_q;
	logic [VC_W-1:0]         v_q;
	logic [2:0]              j_q;
	logic signed [ACC_W-1:0] acc_q;
	logic signed [VAL_W-1:0] uf_q, if_q, err_q, p_q, t_q, nuf_q, nif_q;
	logic [GB_W-1:0]         pred_q;
	logic                    out_valid_q;
	logic [GB_W-1:0]         out_pred_q;
	logic signed [VAL_W-1:0] out_err_q;

	// Table read data.
	logic signed [VAL_W-1:0] uf_rd, if_rd, ub_rd, ib_rd, ctx_rd;

	// Context class of the variable under inspection.
	logic [CLS_W-1:0] c_cur;
	logic             ctx_hit;
	always_comb begin
		c_cur = '0;
		if (int'(v_q) < CONTEXT_VARIABLES) begin
			c_cur = classes_q[CLS_W*v_q +: CLS_W];
		end
	end
	assign ctx_hit = c_cur != '0 && int'(c_cur) < CONTEXT_CLASSES &&
		mask_q[v_q[CVAR_W-1:0]];

	// Shared multiplier.
	logic                    mul_start, mul_done;
	logic signed [MOP_W-1:0] mul_a, mul_b;
	logic signed [VAL_W-1:0] mul_res;

	mfsgd_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.res    (mul_res)
	);

	logic signed [MOP_W-1:0] lr_op, reg_op;
	assign lr_op  = $signed(MOP_W'(lr_q));
	assign reg_op = $signed(MOP_W'(reg_q));

	// Operands of the six update products, in order: err*item, reg*user,
	// step*rate for the user, then err*user, reg*item, step*rate for the item.
	always_comb begin
		mul_a = MOP_W'(if_rd);
		mul_b = MOP_W'(uf_rd);
		if (state_q == S_UPD_GO) begin
			case (j_q)
				3'd0:    begin mul_a = MOP_W'(err_q); mul_b = MOP_W'(if_q); end
				3'd1:    begin mul_a = reg_op;        mul_b = MOP_W'(uf_q); end
				3'd3:    begin mul_a = MOP_W'(err_q); mul_b = MOP_W'(uf_q); end
				3'd4:    begin mul_a = reg_op;        mul_b = MOP_W'(if_q); end
				default: begin mul_a = MOP_W'(t_q);   mul_b = lr_op;        end
			endcase
		end
	end

	// Next state.
	always_comb begin
		state_d   = state_q;
		mul_start = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (accept && u_ok && i_ok &&
					((in_cmd == CMD_TRAIN && f_ok) || in_cmd == CMD_PREDICT)) begin
					state_d = S_BIAS;
				end
			end
			S_BIAS:     state_d = S_BIAS_ADD;
			S_BIAS_ADD: state_d = S_CTX;
			S_CTX: begin
				if (int'(v_q) >= CONTEXT_VARIABLES) begin
					state_d = S_FEAT;
				end else if (ctx_hit) begin
					state_d = S_CTX_ADD;
				end
			end
			S_CTX_ADD: state_d = S_CTX;
			S_FEAT: begin
				state_d = (fcnt_q == n_q) ? S_CLAMP : S_FEAT_LD;
			end
			S_FEAT_LD: begin
				mul_start = 1'b1;
				state_d   = S_FEAT_WAIT;
			end
			S_FEAT_WAIT: begin
				if (mul_done) begin
					state_d = S_FEAT;
				end
			end
			S_CLAMP: state_d = train_q ? S_UPD_GO : S_FIN;
			S_UPD_GO: begin
				mul_start = 1'b1;
				state_d   = S_UPD_WAIT;
			end
			S_UPD_WAIT: begin
				if (mul_done) begin
					state_d = (j_q == 3'd5) ? S_WB : S_UPD_GO;
				end
			end
			S_WB: state_d = S_FIN;
			S_FIN: begin
				if (!out_valid_q || m_axis_tready) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Prediction clamp and error.
	logic signed [ACC_W-1:0] acc_min, acc_max;
	logic [GB_W-1:0]         clamp_w;
	logic signed [MOP_W-1:0] err_w;
	assign acc_min = $signed(ACC_W'(PRED_MIN));
	assign acc_max = $signed(ACC_W'(PRED_MAX));

	always_comb begin
		if (acc_q < acc_min) begin
			clamp_w = PRED_MIN;
		end else if (acc_q > acc_max) begin
			clamp_w = PRED_MAX;
		end else begin
			clamp_w = acc_q[GB_W-1:0];
		end
		err_w = $signed(MOP_W'({score_q, 32'b0})) - $signed(MOP_W'(clamp_w));
	end

	logic signed [MOP_W-1:0] diff_w, upd_u_w, upd_i_w;
	assign diff_w  = MOP_W'(p_q) - MOP_W'(mul_res);
	assign upd_u_w = MOP_W'(uf_q) + MOP_W'(mul_res);
	assign upd_i_w = MOP_W'(if_q) + MOP_W'(mul_res);

	// Control counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fcnt_q      <= '0;
			v_q         <= '0;
			j_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					fcnt_q <= '0;
					v_q    <= '0;
					j_q    <= '0;
				end
				S_CTX: begin
					if (int'(v_q) < CONTEXT_VARIABLES && !ctx_hit) begin
						v_q <= v_q + VC_W'(1);
					end
				end
				S_CTX_ADD: v_q <= v_q + VC_W'(1);
				S_FEAT_WAIT: begin
					if (mul_done) begin
						fcnt_q <= fcnt_q + FC_W'(1);
					end
				end
				S_UPD_WAIT: begin
					if (mul_done) begin
						j_q <= j_q + 3'd1;
					end
				end
				default: ;
			endcase
			if (state_q == S_FIN && (!out_valid_q || m_axis_tready)) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				u_q       <= in_u;
				it_q      <= in_it;
				f_q       <= in_f;
				train_q   <= in_cmd == CMD_TRAIN;
				classes_q <= in_classes;
				score_q   <= in_score;
				if (in_cmd == CMD_TRAIN) begin
					n_q <= FC_W'(in_f) + FC_W'(1);
				end else if (int'(fiu_q) > FEATURES) begin
					n_q <= FC_W'(FEATURES);
				end else begin
					n_q <= FC_W'(fiu_q);
				end
			end
			S_BIAS_ADD: begin
				acc_q <= $signed(ACC_W'(gb_q)) + ACC_W'(ub_rd) + ACC_W'(ib_rd);
			end
			S_CTX_ADD: acc_q <= acc_q + ACC_W'(ctx_rd);
			S_FEAT_LD: begin
				uf_q <= uf_rd;
				if_q <= if_rd;
			end
			S_FEAT_WAIT: begin
				if (mul_done) begin
					acc_q <= acc_q + ACC_W'(mul_res);
				end
			end
			S_CLAMP: begin
				pred_q <= clamp_w;
				err_q  <= train_q ? err_w[VAL_W-1:0] : '0;
			end
			S_UPD_WAIT: begin
				if (mul_done) begin
					case (j_q)
						3'd0, 3'd3: p_q   <= mul_res;
						3'd1, 3'd4: t_q   <= sat48(diff_w);
						3'd2:       nuf_q <= sat48(upd_u_w);
						default:    nif_q <= sat48(upd_i_w);
					endcase
				end
			end
			S_FIN: begin
				if (!out_valid_q || m_axis_tready) begin
					out_pred_q <= pred_q;
					out_err_q  <= err_q;
				end
			end
			default: ;
		endcase
	end

	// Table ports: writes from the stream in idle, reads and write-back later.
	logic              idle;
	logic [FI_W-1:0]   f_sel;
	logic              uf_we, if_we, ub_we, ib_we, ctx_we;
	logic [UF_AW-1:0]  uf_addr;
	logic [IF_AW-1:0]  if_addr;
	logic [UB_AW-1:0]  ub_addr;
	logic [IB_AW-1:0]  ib_addr;
	logic [CTX_AW-1:0] ctx_addr;
	logic [VAL_W-1:0]  uf_wd, if_wd;

	assign idle  = state_q == S_IDLE;
	assign f_sel = (state_q == S_WB) ? f_q : fcnt_q[FI_W-1:0];

	assign uf_we  = (accept && in_cmd == CMD_WR_UFEAT && u_ok && f_ok) || state_q == S_WB;
	assign if_we  = (accept && in_cmd == CMD_WR_IFEAT && i_ok && f_ok) || state_q == S_WB;
	assign ub_we  = accept && in_cmd == CMD_WR_UBIAS && u_ok;
	assign ib_we  = accept && in_cmd == CMD_WR_IBIAS && i_ok;
	assign ctx_we = accept && in_cmd == CMD_WR_CBIAS && u_ok && ctx_ok;

	assign uf_addr = idle ?
		UF_AW'(UF_AW'(in_u) * UF_AW'(FEATURES) + UF_AW'(in_f)) :
		UF_AW'(UF_AW'(u_q) * UF_AW'(FEATURES) + UF_AW'(f_sel));
	assign if_addr = idle ?
		IF_AW'(IF_AW'(in_it) * IF_AW'(FEATURES) + IF_AW'(in_f)) :
		IF_AW'(IF_AW'(it_q) * IF_AW'(FEATURES) + IF_AW'(f_sel));
	assign ub_addr = idle ? UB_AW'(in_u) : UB_AW'(u_q);
	assign ib_addr = idle ? IB_AW'(in_it) : IB_AW'(it_q);
	assign ctx_addr = idle ?
		CTX_AW'((CTX_AW'(in_cv) * CTX_AW'(USERS) + CTX_AW'(in_u)) *
			CTX_AW'(CONTEXT_CLASSES) + CTX_AW'(in_cc)) :
		CTX_AW'((CTX_AW'(v_q) * CTX_AW'(USERS) + CTX_AW'(u_q)) *
			CTX_AW'(CONTEXT_CLASSES) + CTX_AW'(c_cur));
	assign uf_wd = idle ? in_value : nuf_q;
	assign if_wd = idle ? in_value : nif_q;

	mfsgd_ram #(.DEPTH(UF_DEPTH), .WIDTH(VAL_W)) u_uf_ram (
		.clk(clk), .we(uf_we), .addr(uf_addr), .wdata(uf_wd), .rdata(uf_rd)
	);
	mfsgd_ram #(.DEPTH(IF_DEPTH), .WIDTH(VAL_W)) u_if_ram (
		.clk(clk), .we(if_we), .addr(if_addr), .wdata(if_wd), .rdata(if_rd)
	);
	mfsgd_ram #(.DEPTH(USERS), .WIDTH(VAL_W)) u_ub_ram (
		.clk(clk), .we(ub_we), .addr(ub_addr), .wdata(in_value), .rdata(ub_rd)
	);
	mfsgd_ram #(.DEPTH(ITEMS), .WIDTH(VAL_W)) u_ib_ram (
		.clk(clk), .we(ib_we), .addr(ib_addr), .wdata(in_value), .rdata(ib_rd)
	);
	mfsgd_ram #(.DEPTH(CTX_DEPTH), .WIDTH(VAL_W)) u_ctx_ram (
		.clk(clk), .we(ctx_we), .addr(ctx_addr), .wdata(in_value), .rdata(ctx_rd)
	);

	// Ports.
	assign s_axis_tready = idle;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {5'b0, out_err_q, out_pred_q};

	// Checks.
	a_out_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(state_q) == S_FIN)
		else $error("result appeared outside the finish step");

	a_pred_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> out_pred_q >= PRED_MIN && out_pred_q <= PRED_MAX)
		else $error("prediction outside the 1..5 range");

	a_feat_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_FEAT |-> fcnt_q <= n_q)
		else $error("feature counter ran past the feature count");

	a_mul_idle: assert property (@(posedge clk) disable iff (!arst_n)
		mul_start |=> !mul_done)
		else $error("multiplier finished in one cycle");

endmodule

// File: bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the matrix factorization SGD engine
// Drives table loads, train and predict beats with random gaps, predicts each
// result in a Q16.32 model of its own and checks the result stream beat by beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
	import mfsgd_pkg::*;

	// Command code outside the defined set; the engine must drop it.
	localparam logic [2:0] CMD_NONE = 3'd7;
	localparam longint MAX_Q = 64'sh0000_7FFF_FFFF_FFFF;
	localparam longint MIN_Q = -64'sh0000_8000_0000_0000;
	localparam longint ONE_Q = 64'sh1_0000_0000;
	localparam int LIMIT = 3000000;
	localparam int SETTLE = 300;
	localparam int ITEMS_TOTAL = 1050;

	typedef struct {
		logic [2:0]         cmd;
		logic [7:0]         user;
		logic [11:0]        item;
		logic [3:0]         feat;
		logic [3:0]         cvar;
		logic [2:0]         cls;
		logic [35:0]        classes;
		logic [7:0]         score;
		logic signed [47:0] value;
	} beat_t;

	typedef struct {
		logic [34:0] score;
		logic [47:0] err;
	} rating_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         cfg_we = 1'b0;
	logic [2:0]   cfg_index = '0;
	logic [34:0]  cfg_data = '0;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [127:0] s_axis_tdata;
	logic [2:0]   s_axis_tuser;
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [87:0]  m_axis_tdata;

	always #10 clk = ~clk;

	matrix_factorization_sgd_engine dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	// Model state: configuration and the five tables, keyed by flat address.
	longint glob_bias, lrate, decay, nfeat_cfg, ctx_mask;
	longint user_feat[int], item_feat[int], user_bias[int], item_bias[int];
	longint ctx_bias[int];

	beat_t   pending[$];
	rating_t ratings_due[$];
	int      errors = 0;
	int      pushed = 0;
	bit      quiet = 1'b0;

	// Written-entry bookkeeping on the stimulus side, so that no beat ever reads
	// a table entry that the engine has not been given.
	bit loaded_uf[int], loaded_if[int], loaded_ub[int], loaded_ib[int], loaded_cb[int];
	logic [7:0]  user_pool[8];
	logic [11:0] item_pool[8];

	task automatic report(input string what, input logic [87:0] got, input rating_t want);
		$display("mismatch %s: got score %h err %h, want score %h err %h at %0t",
			what, got[34:0], got[82:35], want.score, want.err, $realtime);
		errors++;
	endtask

	function automatic longint clip48(input longint x);
		if (x > MAX_Q) return MAX_Q;
		if (x < MIN_Q) return MIN_Q;
		return x;
	endfunction

	// Fixed-point product: exact, magnitude rounded half up at bit 32, saturated.
	function automatic longint qmul(input longint a, input longint b);
		logic signed [127:0] p;
		logic [127:0] m;
		p = 128'(a) * 128'(b);
		m = p[127] ? -p : p;
		m = (m + 128'h8000_0000) >> 32;
		if (p[127]) return (m > 128'h8000_0000_0000) ? MIN_Q : -longint'(m);
		return (m > 128'(MAX_Q)) ? MAX_Q : longint'(m);
	endfunction

	function automatic longint rate_item(input int u, input int it, input int nf,
			input logic [35:0] classes);
		longint acc;
		int c;
		acc = glob_bias + user_bias[u] + item_bias[it];
		for (int v = 0; v < 12; v++) begin
			c = classes[3*v +: 3];
			if (c != 0 && ctx_mask[v]) acc += ctx_bias[(v*256 + u)*8 + c];
		end
		for (int f = 0; f < nf && f < 16; f++)
			acc += qmul(item_feat[it*16 + f], user_feat[u*16 + f]);
		if (acc < ONE_Q) acc = ONE_Q;
		if (acc > 5*ONE_Q) acc = 5*ONE_Q;
		return acc;
	endfunction

	// Apply one accepted beat to the model and queue the rating it must produce.
	task automatic absorb(input beat_t b);
		longint pred, err, uf, itf;
		int ui, ii;
		rating_t r;
		ui = b.user*16 + b.feat;
		ii = b.item*16 + b.feat;
		case (b.cmd)
			CMD_WR_UFEAT: user_feat[ui] = b.value;
			CMD_WR_IFEAT: item_feat[ii] = b.value;
			CMD_WR_UBIAS: user_bias[b.user] = b.value;
			CMD_WR_IBIAS: item_bias[b.item] = b.value;
			CMD_WR_CBIAS: if (b.cvar < 12) ctx_bias[(b.cvar*256 + b.user)*8 + b.cls] = b.value;
			CMD_TRAIN: begin
				pred = rate_item(b.user, b.item, b.feat + 1, b.classes);
				err = longint'(b.score) * ONE_Q - pred;
				uf = user_feat[ui];
				itf = item_feat[ii];
				// Both features step from their old values.
				user_feat[ui] = clip48(uf + qmul(clip48(qmul(err, itf) - qmul(decay, uf)), lrate));
				item_feat[ii] = clip48(itf + qmul(clip48(qmul(err, uf) - qmul(decay, itf)), lrate));
				r.score = pred[34:0];
				r.err = err[47:0];
				ratings_due.push_back(r);
			end
			CMD_PREDICT: begin
				pred = rate_item(b.user, b.item, nfeat_cfg, b.classes);
				r.score = pred[34:0];
				r.err = '0;
				ratings_due.push_back(r);
			end
			default: ;
		endcase
	endtask

	// Input side: one beat held until accepted, random gaps between beats.
	int    src_gap = 0;
	bit    nv;
	beat_t cur;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
			s_axis_tuser <= '0;
		end else begin
			nv = s_axis_tvalid;
			if (s_axis_tvalid && s_axis_tready) begin
				absorb(cur);
				nv = 1'b0;
			end
			if (!nv) begin
				if (src_gap > 0) begin
					src_gap--;
				end else if (pending.size() > 0) begin
					if (!quiet && $urandom_range(0, 9) == 0) begin
						src_gap = $urandom_range(0, 17);
					end else begin
						cur = pending.pop_front();
						s_axis_tdata <= {5'd0, cur.value, cur.score, cur.classes, cur.cls,
							cur.cvar, cur.feat, cur.item, cur.user};
						s_axis_tuser <= cur.cmd;
						nv = 1'b1;
					end
				end
			end
			s_axis_tvalid <= nv;
		end
	end

	// Result side: random stall bursts, each beat checked against the oldest rating.
	int sink_gap = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (ratings_due.size() == 0) begin
					report("unexpected beat", m_axis_tdata, '{default: '0});
				end else if (m_axis_tdata[34:0] !== ratings_due[0].score) begin
					report("predicted_score", m_axis_tdata, ratings_due.pop_front());
				end else if (m_axis_tdata[82:35] !== ratings_due[0].err) begin
					report("error", m_axis_tdata, ratings_due.pop_front());
				end else begin
					void'(ratings_due.pop_front());
				end
			end
			if (sink_gap > 0) begin
				sink_gap--;
				m_axis_tready <= 1'b0;
			end else if (!quiet && $urandom_range(0, 9) == 0) begin
				sink_gap = $urandom_range(0, 17);
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// Watchdog.
	int cycles = 0;

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("testbench NOT OK");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Stimulus construction
	// ------------------------------------------------------------------

	// Mix of full-range, small, tiny and saturating Q16.32 values.
	function automatic logic signed [47:0] pick_value();
		case ($urandom_range(0, 5))
			0: return 48'({$urandom, $urandom});
			1: return 48'(MAX_Q);
			2: return 48'(MIN_Q);
			3: return 48'($signed({$urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0, $urandom}));
			default: return 48'($signed(64'($urandom_range(0, 32'h3_FFFF))
				- 64'h2_0000) <<< 14);
		endcase
	endfunction

	task automatic push_write(input logic [2:0] cmd, input int u, input int it, input int f,
			input int cv, input int c, input logic signed [47:0] val);
		beat_t b;
		b.cmd = cmd;
		b.user = 8'(u);
		b.item = 12'(it);
		b.feat = 4'(f);
		b.cvar = 4'(cv);
		b.cls = 3'(c);
		b.classes = 36'({$urandom, $urandom});
		b.score = 8'($urandom);
		b.value = val;
		pending.push_back(b);
		pushed++;
		case (cmd)
			CMD_WR_UFEAT: loaded_uf[u*16 + f] = 1'b1;
			CMD_WR_IFEAT: loaded_if[it*16 + f] = 1'b1;
			CMD_WR_UBIAS: loaded_ub[u] = 1'b1;
			CMD_WR_IBIAS: loaded_ib[it] = 1'b1;
			CMD_WR_CBIAS: if (cv < 12) loaded_cb[(cv*256 + u)*8 + c] = 1'b1;
			default: ;
		endcase
	endtask

	// A train or predict beat, preceded by loads of any entry it would read
	// that has never been written.
	task automatic push_rating(input logic [2:0] cmd, input int u, input int it, input int f,
			input logic [35:0] classes, input logic [7:0] score);
		beat_t b;
		int nf, c;
		nf = (cmd == CMD_TRAIN) ? f + 1 : (nfeat_cfg > 16 ? 16 : int'(nfeat_cfg));
		for (int k = 0; k < nf; k++) begin
			if (!loaded_uf.exists(u*16 + k)) push_write(CMD_WR_UFEAT, u, 0, k, 0, 0, pick_value());
			if (!loaded_if.exists(it*16 + k)) push_write(CMD_WR_IFEAT, 0, it, k, 0, 0, pick_value());
		end
		if (!loaded_ub.exists(u)) push_write(CMD_WR_UBIAS, u, 0, 0, 0, 0, pick_value());
		if (!loaded_ib.exists(it)) push_write(CMD_WR_IBIAS, 0, it, 0, 0, 0, pick_value());
		for (int v = 0; v < 12; v++) begin
			c = classes[3*v +: 3];
			if (c != 0 && ctx_mask[v] && !loaded_cb.exists((v*256 + u)*8 + c))
				push_write(CMD_WR_CBIAS, u, 0, 0, v, c, pick_value());
		end
		b.cmd = cmd;
		b.user = 8'(u);
		b.item = 12'(it);
		b.feat = 4'(f);
		b.cvar = 4'($urandom);
		b.cls = 3'($urandom);
		b.classes = classes;
		b.score = score;
		b.value = 48'({$urandom, $urandom});
		pending.push_back(b);
		pushed++;
	endtask

	function automatic logic [7:0] pick_score();
		return $urandom_range(0, 7) == 0 ? 8'($urandom) : 8'($urandom_range(1, 5));
	endfunction

	task automatic push_random();
		int u, it, sel;
		u = user_pool[$urandom_range(0, 7)];
		it = item_pool[$urandom_range(0, 7)];
		sel = $urandom_range(0, 99);
		if (sel < 40) begin
			push_rating(CMD_PREDICT, u, it, $urandom, 36'({$urandom, $urandom}),
				8'($urandom));
		end else if (sel < 72) begin
			push_rating(CMD_TRAIN, u, it, $urandom_range(0, 15),
				36'({$urandom, $urandom}), pick_score());
		end else if (sel < 80) begin
			push_write(CMD_WR_CBIAS, $urandom_range(0, 1) ? u : $urandom, 0, 0,
				$urandom_range(0, 11), $urandom, pick_value());
		end else if (sel < 95) begin
			// Overwrite a user or item feature or bias entry, in the pool or anywhere else.
			push_write(3'($urandom_range(0, 3)), $urandom_range(0, 1) ? u : $urandom,
				$urandom_range(0, 1) ? it : $urandom, $urandom, 0, 0, pick_value());
		end else begin
			// Beats the engine must drop: unknown command, context variable out of range.
			push_write($urandom_range(0, 1) ? CMD_NONE : CMD_WR_CBIAS, $urandom, $urandom,
				$urandom, $urandom_range(12, 15), $urandom, pick_value());
		end
	endtask

	task automatic drain();
		do @(posedge clk);
		while (pending.size() != 0 || s_axis_tvalid || ratings_due.size() != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input longint val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val[34:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_GLOBAL_BIAS:   glob_bias = val & 64'h7_FFFF_FFFF;
			CFG_LEARNING_RATE: lrate = val & 64'hFFFF_FFFF;
			CFG_REGULARIZE:    decay = val & 64'hFFFF_FFFF;
			CFG_FEATURES:      nfeat_cfg = val & 64'h1F;
			default:           ctx_mask = val & 64'hFFF;
		endcase
	endtask

	initial begin
		glob_bias = 0;
		lrate = 42950;
		decay = 21474836;
		nfeat_cfg = 10;
		ctx_mask = 1052;
		user_pool[0] = 8'd0;
		user_pool[1] = 8'd255;
		item_pool[0] = 12'd0;
		item_pool[1] = 12'd4095;
		for (int i = 2; i < 8; i++) begin
			user_pool[i] = 8'($urandom);
			item_pool[i] = 12'($urandom);
		end
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed beats at reset settings: field extremes, every command,
		// dropped beats and class zero.
		push_write(CMD_WR_UFEAT, 255, 0, 15, 0, 0, 48'(MAX_Q));
		push_write(CMD_WR_IFEAT, 0, 4095, 15, 0, 0, 48'(MIN_Q));
		push_write(CMD_WR_UBIAS, 0, 0, 0, 0, 0, 48'(ONE_Q));
		push_write(CMD_WR_IBIAS, 0, 4095, 0, 0, 0, -48'(ONE_Q));
		push_write(CMD_WR_CBIAS, 255, 0, 0, 11, 7, 48'(MAX_Q));
		push_write(CMD_WR_CBIAS, 0, 0, 0, 15, 7, 48'(MIN_Q));
		push_write(CMD_NONE, 255, 4095, 15, 11, 7, 48'(MAX_Q));
		push_rating(CMD_PREDICT, 0, 0, 0, 36'h0, 0);
		push_rating(CMD_PREDICT, 255, 4095, 15, 36'hF_FFFF_FFFF, 255);
		push_rating(CMD_TRAIN, 255, 4095, 15, 36'hF_FFFF_FFFF, 255);
		push_rating(CMD_TRAIN, 0, 0, 0, 36'h0, 0);
		push_rating(CMD_TRAIN, 255, 0, 3, 36'h9_2492_4924, 5);
		drain();

		// Random phases, each under its own register setting; the sender waits
		// for every rating before the registers change.
		for (int phase = 0; phase < 7; phase++) begin
			case (phase)
				0: ;
				1: begin
					write_reg(CFG_GLOBAL_BIAS, 64'h3_8000_0000);
					write_reg(CFG_LEARNING_RATE, 64'h0100_0000);
					write_reg(CFG_REGULARIZE, 64'h0800_0000);
					write_reg(CFG_FEATURES, 16);
					write_reg(CFG_CONTEXT_MASK, 12'hFFF);
				end
				2: begin
					write_reg(CFG_GLOBAL_BIAS, 0);
					write_reg(CFG_LEARNING_RATE, 0);
					write_reg(CFG_REGULARIZE, 0);
					write_reg(CFG_FEATURES, 1);
					write_reg(CFG_CONTEXT_MASK, 0);
				end
				3: begin
					write_reg(CFG_GLOBAL_BIAS, 64'h5_0000_0000);
					write_reg(CFG_LEARNING_RATE, 64'hFFFF_FFFF);
					write_reg(CFG_REGULARIZE, 64'hFFFF_FFFF);
					write_reg(CFG_FEATURES, 31);
					write_reg(CFG_CONTEXT_MASK, 12'hA5A);
				end
				4: begin
					write_reg(CFG_FEATURES, 0);
					write_reg(CFG_CONTEXT_MASK, 12'h5A5);
					write_reg(CFG_GLOBAL_BIAS, 64'h1_4000_0000);
				end
				default: begin
					write_reg(CFG_GLOBAL_BIAS, 64'($urandom_range(0, 5)) << 32);
					write_reg(CFG_LEARNING_RATE, $urandom_range(0, 32'h0400_0000));
					write_reg(CFG_REGULARIZE, $urandom);
					write_reg(CFG_FEATURES, $urandom_range(1, 16));
					write_reg(CFG_CONTEXT_MASK, $urandom_range(0, 4095));
				end
			endcase
			// The last phase runs with both sides always ready.
			quiet = (phase == 6);
			// Table loads count toward the total, so each phase fills up to its share.
			while (pushed < ITEMS_TOTAL * (phase + 1) / 7) push_random();
			drain();
		end

		if (errors == 0) begin
			$display("testbench OK");
		end else begin
			$display("testbench NOT OK");
		end
		$finish;
	end

endmodule

// File: sim.f
design/mfsgd_pkg.sv
design/mfsgd_ram.sv
design/mfsgd_mul.sv
design/matrix_factorization_sgd_engine.sv
bench/testbench.sv
